// ===== design/mb32_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mb32_pkg
// Shared types and constants for the Mulberry32 draw pipeline.
// ----------------------------------------------------------------------------
package mb32_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned PROB_W = 33;

  localparam logic [WORD_W-1:0] MB32_INCREMENT = 32'h6d2b79f5;
  localparam logic [WORD_W-1:0] MB32_OR_A      = 32'd1;
  localparam logic [WORD_W-1:0] MB32_OR_B      = 32'd61;
  localparam int unsigned       MB32_SHIFT_A   = 15;
  localparam int unsigned       MB32_SHIFT_B   = 7;
  localparam int unsigned       MB32_SHIFT_C   = 14;

  // Operation codes; the spare code behaves as a plain fraction draw.
  typedef enum logic [1:0] {
    OP_FRACTION = 2'd0,
    OP_RANGE    = 2'd1,
    OP_CHANCE   = 2'd2
  } op_t;

  // Side-band data that rides along the mixer stages.
  typedef struct packed {
    op_t                op;
    logic [WORD_W-1:0]  low;
    logic [WORD_W-1:0]  span;
    logic [PROB_W-1:0]  prob;
  } draw_ctl_t;

  // What leaves the mixer.
  typedef struct packed {
    logic [WORD_W-1:0]  seed;
    logic [WORD_W-1:0]  word;
    draw_ctl_t          ctl;
  } mix_out_t;

endpackage
`default_nettype wire

// ===== design/mb32_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mb32_in_if
// Request channel: operation, seed and draw arguments.
// ----------------------------------------------------------------------------
interface mb32_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] seed_in;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;
  logic [32:0] probability_scaled;

  modport source (
    output valid, operation, seed_in, range_low, range_high, probability_scaled,
    input  ready
  );
  modport sink (
    input  valid, operation, seed_in, range_low, range_high, probability_scaled,
    output ready
  );
endinterface
`default_nettype wire

// ===== design/mb32_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mb32_out_if
// Result channel: next seed, fraction, range value and chance hit.
// ----------------------------------------------------------------------------
interface mb32_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] new_seed;
  logic [31:0] random_fraction;
  logic signed [31:0] range_value;
  logic        hit;

  modport source (
    output valid, new_seed, random_fraction, range_value, hit,
    input  ready
  );
  modport sink (
    input  valid, new_seed, random_fraction, range_value, hit,
    output ready
  );
endinterface
`default_nettype wire

// ===== design/mulberry32_random_draw_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mulberry32_random_draw_top
// Stateless Mulberry32 draw: next seed, 0.32 fraction, range and chance.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  in_ch     sink       operation, seed_in, range_low, range_high,
//                       probability_scaled
//  out_ch    source     new_seed, random_fraction, range_value, hit
//
//  Throughput is one transfer per cycle while out_ch accepts results; an
//  input transfer reaches out_ch through the registered stages listed below.
//  Stages: seed add, first multiply, second multiply, fold, range product
//  with chance compare, range add into the output register.
//  Reset (rst_n low at a clock edge) clears the valid bits only.
//  A stall on out_ch holds each full stage whose successor is full; empty
//  stages keep filling, so bubbles are squeezed out and nothing is lost.
// ----------------------------------------------------------------------------
module mulberry32_random_draw_top
  import mb32_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  mb32_in_if.sink    in_ch,
  mb32_out_if.source out_ch
);

  draw_ctl_t in_ctl;
  logic      mix_valid;
  logic      mix_ready;
  mix_out_t  mix_data;

  // Span wraps at 32 bits and is read as signed further down.
  assign in_ctl.op   = op_t'(in_ch.operation);
  assign in_ctl.low  = in_ch.range_low;
  assign in_ctl.span = in_ch.range_high - in_ch.range_low;
  assign in_ctl.prob = in_ch.probability_scaled;

  // Stages one to four: the Mulberry32 step itself.
  mb32_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_seed   (in_ch.seed_in),
    .in_ctl    (in_ctl),
    .out_valid (mix_valid),
    .out_ready (mix_ready),
    .out_data  (mix_data)
  );

  // Stage five: signed range product and chance compare.
  logic              v5_r;
  logic              adv5;
  logic [WORD_W-1:0] seed5_r, word5_r, low5_r, prod_hi5_r;
  op_t               op5_r;
  logic              hit5_r;

  logic signed [2*WORD_W:0] prod_nxt;
  logic                     hit_nxt;

  // Unsigned word times signed span, exact; the upper half is the floor.
  assign prod_nxt = $signed({1'b0, mix_data.word}) * $signed(mix_data.ctl.span);

  always_comb begin
    unique case (mix_data.ctl.op)
      OP_CHANCE: hit_nxt = ({1'b0, mix_data.word} < mix_data.ctl.prob);
      default:   hit_nxt = 1'b0;
    endcase
  end

  // Stage six: the output register.
  logic              v6_r;
  logic              adv6;
  logic [WORD_W-1:0] seed6_r, word6_r, value6_r;
  op_t               op6_r;
  logic              hit6_r;
  logic [WORD_W-1:0] value_nxt;

  always_comb begin
    unique case (op5_r)
      OP_RANGE: value_nxt = low5_r + prod_hi5_r;
      default:  value_nxt = '0;
    endcase
  end

  // Advance a stage when it is empty or the next one moves.
  assign adv6      = !v6_r || out_ch.ready;
  assign adv5      = !v5_r || adv6;
  assign mix_ready = adv5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (adv5) v5_r <= mix_valid;
      if (adv6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      seed5_r    <= mix_data.seed;
      word5_r    <= mix_data.word;
      low5_r     <= mix_data.ctl.low;
      op5_r      <= mix_data.ctl.op;
      prod_hi5_r <= prod_nxt[2*WORD_W-1:WORD_W];
      hit5_r     <= hit_nxt;
    end
    if (adv6) begin
      seed6_r  <= seed5_r;
      word6_r  <= word5_r;
      value6_r <= value_nxt;
      op6_r    <= op5_r;
      hit6_r   <= hit5_r;
    end
  end

  assign out_ch.valid           = v6_r;
  assign out_ch.new_seed        = seed6_r;
  assign out_ch.random_fraction = word6_r;
  assign out_ch.range_value     = value6_r;
  assign out_ch.hit             = hit6_r;

  // With the output register empty the whole pipe must be open.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with an empty output register");

  // Range value is zero outside range mode.
  a_value_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && op6_r != OP_RANGE) |-> (value6_r == '0))
    else $error("range value set outside range mode");

  // Hit is only raised in chance mode.
  a_hit_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (v6_r && hit6_r) |-> (op6_r == OP_CHANCE))
    else $error("hit set outside chance mode");

  // The output register only fills from a full stage five.
  a_v6_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v6_r) |-> $past(v5_r))
    else $error("output register filled from an empty stage");

endmodule
`default_nettype wire

// ===== design/mb32_mix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mb32_mix
// Four-stage Mulberry32 mixer: add, multiply, multiply, fold.
// ----------------------------------------------------------------------------
module mb32_mix
  import mb32_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WORD_W-1:0] in_seed,
  input  wire draw_ctl_t         in_ctl,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mix_out_t               out_data
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic adv1, adv2, adv3, adv4;

  logic [WORD_W-1:0] t0_r, t1_r, t1b_r, u_r, t2_r, word_r;
  draw_ctl_t         ctl1_r, ctl2_r, ctl3_r, ctl4_r;

  logic [WORD_W-1:0] t1_nxt, u_nxt, t2_nxt, word_nxt;

  // A stage takes new data when it is empty or its successor moves.
  assign adv4     = !v4_r || out_ready;
  assign adv3     = !v3_r || adv4;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  assign t1_nxt   = (t0_r ^ (t0_r >> MB32_SHIFT_A)) * (t0_r | MB32_OR_A);
  assign u_nxt    = (t1_r ^ (t1_r >> MB32_SHIFT_B)) * (t1_r | MB32_OR_B);
  assign t2_nxt   = t1b_r ^ (t1b_r + u_r);
  assign word_nxt = t2_nxt ^ (t2_nxt >> MB32_SHIFT_C);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      t0_r   <= in_seed + MB32_INCREMENT;
      ctl1_r <= in_ctl;
    end
    if (adv2) begin
      t1_r   <= t1_nxt;
      ctl2_r <= ctl1_r;
    end
    if (adv3) begin
      t1b_r  <= t1_r;
      u_r    <= u_nxt;
      ctl3_r <= ctl2_r;
    end
    if (adv4) begin
      t2_r   <= t2_nxt;
      word_r <= word_nxt;
      ctl4_r <= ctl3_r;
    end
  end

  assign out_valid     = v4_r;
  assign out_data.seed = t2_r;
  assign out_data.word = word_r;
  assign out_data.ctl  = ctl4_r;

  // A stage only fills from the one before it.
  a_v2_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v2_r) |-> $past(v1_r))
    else $error("mix stage 2 filled from an empty stage 1");

  a_v4_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(v4_r) |-> $past(v3_r))
    else $error("mix stage 4 filled from an empty stage 3");

  // A full last stage held back by the sink must keep its word.
  a_v4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && !out_ready) |=> (v4_r && $stable(word_r) && $stable(t2_r)))
    else $error("mix output changed while stalled");

endmodule
`default_nettype wire

// ===== tb/sv/tb_mulberry32_random_draw_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mulberry32_random_draw_top
// Self-checking bench for the Mulberry32 draw pipeline: a queue-fed driver
// pushes seeds and draw arguments in bursts, a clocked monitor scores every
// result against an in-bench model of the mixer, range map and chance test.
// ----------------------------------------------------------------------------
module tb_mulberry32_random_draw_top;
  import mb32_pkg::*;

  // Spare operation code; the block treats it as a plain fraction draw.
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam int RESET_CYCLES  = 7;
  localparam int RANDOM_DRAWS  = 1800;
  localparam int DRAIN_EVERY   = 600;  // force a full drain this often
  localparam int TAIL_CYCLES   = 24;   // idle tail after the last result, longer than the six-stage pipeline
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PRINT_LIMIT   = 40;

  // One request as the sender presents it.
  typedef struct {
    logic [1:0]  op;
    logic [31:0] seed;
    logic [31:0] low;
    logic [31:0] high;
    logic [32:0] prob;
    bit          drain_first;  // hold off until the pipeline is empty
  } draw_req_t;

  // One result as the block should return it.
  typedef struct {
    logic [31:0] seed;
    logic [31:0] fraction;
    logic [31:0] value;
    logic        hit;
  } draw_res_t;

  logic clk;
  logic rst_n;

  mb32_in_if  in_ch ();
  mb32_out_if out_ch ();

  mulberry32_random_draw_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  draw_req_t pending_draws[$];   // requests not yet presented
  draw_res_t expected_draws[$];  // results owed by the pipeline, oldest first
  draw_req_t shown_draw;         // request currently on in_ch

  int  cycle_count    = 0;
  int  mismatch_count = 0;
  int  stall_cycles   = 0;
  int  drain_pauses   = 0;
  int  op_count[4]    = '{default: 0};
  int  hit_count      = 0;
  int  burst_left     = 0;
  int  gap_left       = 0;
  int  stall_mode     = 0;
  logic in_xfer       = 1'b0;    // request transfer seen at the last rising edge

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // --------------------------------------------------------------------------
  // Model of one draw: Mulberry32 step, then the range map or chance test.
  // --------------------------------------------------------------------------
  function automatic draw_res_t predict_draw(input draw_req_t req);
    draw_res_t          res;
    logic [31:0]        t;
    logic [31:0]        span;
    logic signed [63:0] prod;
    t = req.seed + MB32_INCREMENT;
    t = (t ^ (t >> MB32_SHIFT_A)) * (t | MB32_OR_A);
    t = t ^ (t + (t ^ (t >> MB32_SHIFT_B)) * (t | MB32_OR_B));
    res.seed     = t;
    res.fraction = t ^ (t >> MB32_SHIFT_C);
    res.value    = '0;
    res.hit      = 1'b0;
    if (req.op == OP_RANGE) begin
      // Span wraps at 32 bits and is read as signed; the product is exact and
      // its upper half is the floor of word * span / 2^32.
      span      = req.high - req.low;
      prod      = $signed({32'd0, res.fraction}) * $signed({{32{span[31]}}, span});
      res.value = req.low + prod[63:32];
    end else if (req.op == OP_CHANCE) begin
      res.hit = ({1'b0, res.fraction} < req.prob);
    end
    return res;
  endfunction

  function automatic draw_req_t make_draw(input logic [1:0] op, input logic [31:0] seed,
                                          input logic [31:0] low, input logic [31:0] high,
                                          input logic [32:0] prob);
    draw_req_t req;
    req.op          = op;
    req.seed        = seed;
    req.low         = low;
    req.high        = high;
    req.prob        = prob;
    req.drain_first = 1'b0;
    return req;
  endfunction

  task automatic report_mismatch(input string what, input logic [32:0] got,
                                 input logic [32:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("[%0t] %s: got %h, expected %h", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length, random gaps between them.
  // A request marked drain_first waits until every owed result has come.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    logic next_valid;
    next_valid = in_ch.valid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!in_ch.valid || in_xfer) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_draws.size() != 0) begin
        if (pending_draws[0].drain_first && expected_draws.size() != 0) begin
          // hold until the pipeline has drained
        end else begin
          if (pending_draws[0].drain_first) drain_pauses++;
          shown_draw                  = pending_draws.pop_front();
          in_ch.operation          <= shown_draw.op;
          in_ch.seed_in            <= shown_draw.seed;
          in_ch.range_low          <= shown_draw.low;
          in_ch.range_high         <= shown_draw.high;
          in_ch.probability_scaled <= shown_draw.prob;
          next_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            // Mostly short bursts; now and then a long back-to-back stretch.
            burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100)
                                                      : $urandom_range(16, 1);
            gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
          end
        end
      end
    end
    in_ch.valid <= next_valid;
  end

  // --------------------------------------------------------------------------
  // Result receiver: stall mode is redrawn at random between always ready,
  // random stalls and a fixed pattern that is ready two thirds of the time.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    logic next_ready;
    if (cycle_count % 256 == 0) stall_mode = $urandom_range(2, 0);
    case (stall_mode)
      0: next_ready = 1'b1;
      1: next_ready = ($urandom_range(99, 0) < 65);
      default: next_ready = ((cycle_count % 9) < 6);
    endcase
    if (!rst_n) next_ready = 1'b0;
    else if (!next_ready) stall_cycles++;
    out_ch.ready <= next_ready;
  end

  // --------------------------------------------------------------------------
  // Monitor: score each result transfer, then record each request transfer.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    draw_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_draws.size() == 0) begin
        report_mismatch("result transfer with nothing pending", {1'b0, out_ch.new_seed}, '0);
      end else begin
        want = expected_draws.pop_front();
        if (out_ch.new_seed !== want.seed)
          report_mismatch("new_seed", {1'b0, out_ch.new_seed}, {1'b0, want.seed});
        if (out_ch.random_fraction !== want.fraction)
          report_mismatch("random_fraction", {1'b0, out_ch.random_fraction},
                          {1'b0, want.fraction});
        if (out_ch.range_value !== want.value)
          report_mismatch("range_value", {1'b0, out_ch.range_value}, {1'b0, want.value});
        if (out_ch.hit !== want.hit)
          report_mismatch("hit", {32'd0, out_ch.hit}, {32'd0, want.hit});
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      want = predict_draw(shown_draw);
      expected_draws.push_back(want);
      op_count[shown_draw.op]++;
      if (want.hit) hit_count++;
    end
    in_xfer <= rst_n && in_ch.valid && in_ch.ready;
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    draw_req_t   req;
    draw_res_t   peek;
    logic [31:0] chain_seed;
    int          pick;
    int          flavor;

    rst_n                    = 1'b0;
    in_ch.valid              = 1'b0;
    in_ch.operation          = '0;
    in_ch.seed_in            = '0;
    in_ch.range_low          = '0;
    in_ch.range_high         = '0;
    in_ch.probability_scaled = '0;
    out_ch.ready             = 1'b0;
    shown_draw               = make_draw(OP_FRACTION, '0, '0, '0, '0);

    // Directed part: seed extremes, every code, range and chance corners.
    pending_draws.push_back(make_draw(OP_FRACTION, 32'h0000_0000, $urandom, $urandom,
                                      {1'b0, $urandom}));
    pending_draws.push_back(make_draw(OP_FRACTION, 32'hffff_ffff, 32'h7fff_ffff,
                                      32'h8000_0000, 33'h1_0000_0000));
    // Seed plus increment wraps to zero.
    pending_draws.push_back(make_draw(OP_FRACTION, 32'h0 - MB32_INCREMENT, '0, '0, '0));
    // Spare code with live range and probability fields: no value, no hit.
    pending_draws.push_back(make_draw(OP_SPARE, $urandom, 32'h8000_0000, 32'h7fff_ffff,
                                      33'h1_0000_0000));
    // List index pick, then a unit span.
    pending_draws.push_back(make_draw(OP_RANGE, $urandom, 32'd0, 32'd10, '0));
    pending_draws.push_back(make_draw(OP_RANGE, $urandom, 32'd0, 32'd1, '0));
    // Full signed range: span wraps to -1, and the sum wraps past the bottom.
    pending_draws.push_back(make_draw(OP_RANGE, $urandom, 32'h8000_0000, 32'h7fff_ffff, '0));
    // Reversed extremes: span wraps to +1.
    pending_draws.push_back(make_draw(OP_RANGE, $urandom, 32'h7fff_ffff, 32'h8000_0000, '0));
    // Span of exactly 2^31 reads as the most negative value.
    pending_draws.push_back(make_draw(OP_RANGE, $urandom, 32'h8000_0000, 32'h0000_0000, '0));
    pending_draws.push_back(make_draw(OP_RANGE, $urandom, 32'h7fff_ffff, 32'hffff_ffff, '0));
    // Empty, reversed and ordinary small ranges.
    pending_draws.push_back(make_draw(OP_RANGE, $urandom, 32'd5, 32'd5, '0));
    pending_draws.push_back(make_draw(OP_RANGE, $urandom, 32'd100, 32'hffff_ff9c, '0));
    pending_draws.push_back(make_draw(OP_RANGE, 32'hffff_ffff, 32'hffff_fc18, 32'd1000,
                                      33'h1_ffff_ffff & 33'h0_ffff_ffff));
    // Chance: never, always, just under one, smallest nonzero, one half.
    pending_draws.push_back(make_draw(OP_CHANCE, $urandom, '0, '0, 33'h0));
    pending_draws.push_back(make_draw(OP_CHANCE, $urandom, '0, '0, 33'h1_0000_0000));
    pending_draws.push_back(make_draw(OP_CHANCE, 32'h0, '0, '0, 33'h0_ffff_ffff));
    pending_draws.push_back(make_draw(OP_CHANCE, $urandom, '0, '0, 33'h1));
    pending_draws.push_back(make_draw(OP_CHANCE, 32'hffff_ffff, '0, '0, 33'h0_8000_0000));
    // Probability equal to the word misses; one above it hits.
    req  = make_draw(OP_CHANCE, $urandom, $urandom, $urandom, '0);
    peek = predict_draw(req);
    req.prob = {1'b0, peek.fraction};
    pending_draws.push_back(req);
    req.prob = {1'b0, peek.fraction} + 33'd1;
    pending_draws.push_back(req);

    // Random part: seeds are fresh, near the extremes, or chained as a caller would.
    chain_seed = $urandom;
    for (int i = 0; i < RANDOM_DRAWS; i++) begin
      pick = $urandom_range(99, 0);
      if (pick < 20)      req.op = OP_FRACTION;
      else if (pick < 58) req.op = OP_RANGE;
      else if (pick < 95) req.op = OP_CHANCE;
      else                req.op = OP_SPARE;

      case ($urandom_range(9, 0))
        0:       req.seed = 32'h0;
        1:       req.seed = 32'hffff_ffff;
        2:       req.seed = 32'h0 - MB32_INCREMENT + $urandom_range(2, 0) - 32'd1;
        3, 4, 5: req.seed = chain_seed;
        default: req.seed = $urandom;
      endcase

      flavor = $urandom_range(5, 0);
      case (flavor)
        0: begin
          req.low  = $urandom;
          req.high = $urandom;
        end
        1: begin
          req.low  = 32'd0;
          req.high = $urandom_range(1000, 1);
        end
        2: begin
          req.low  = $urandom_range(2000, 0) - 32'd1000;
          req.high = req.low + $urandom_range(64, 1);
        end
        3: begin
          req.low  = $urandom;
          req.high = req.low;
        end
        4: begin
          req.low  = $urandom_range(2000, 0) - 32'd1000;
          req.high = req.low - $urandom_range(64, 1);
        end
        default: begin
          req.low  = 32'h8000_0000 + $urandom_range(3, 0);
          req.high = 32'h7fff_ffff - $urandom_range(3, 0);
          if ($urandom_range(1, 0) == 1) begin
            // swap the ends so the span wraps the other way
            chain_seed = req.low;
            req.low    = req.high;
            req.high   = chain_seed;
          end
        end
      endcase

      req.prob = '0;
      peek = predict_draw(req);
      case ($urandom_range(5, 0))
        0:       req.prob = 33'h0;
        1:       req.prob = 33'h1_0000_0000;
        2:       req.prob = {1'b0, peek.fraction} + $urandom_range(1, 0);
        3:       req.prob = {1'b0, peek.fraction} - $urandom_range(1, 0);
        default: req.prob = {1'b0, $urandom};
      endcase
      req.drain_first = (i % DRAIN_EVERY == 0);
      pending_draws.push_back(req);
      chain_seed = peek.seed;
    end

    // Reset, then release on a falling edge.
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for the last request transfer, then for every owed result.
    while (pending_draws.size() != 0 || in_ch.valid) @(negedge clk);
    while (expected_draws.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Scored %0d draws: %0d fraction, %0d range, %0d chance (%0d hits), %0d spare code",
             op_count[0] + op_count[1] + op_count[2] + op_count[3], op_count[0],
             op_count[1], op_count[2], hit_count, op_count[3]);
    $display("Sender drained the pipeline %0d times; receiver held off %0d cycles",
             drain_pauses, stall_cycles);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
